>>> rtl/cia_pkg.sv
// shared types and constants of the checked integer alu
package cia_pkg;

   // widths of the item fields
   localparam int unsigned OP_WIDTH           = 2;
   localparam int unsigned FIELD_WIDTH        = 64;
   localparam int unsigned DATA_WIDTH_DEFAULT = 64;

   // operation codes
   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

endpackage

>>> rtl/checked_int64_alu.sv
// top level of the checked signed integer alu
//
// usage
// - req channel: req_valid with req_operation, req_left_operand and
//   req_right_operand; an item is taken on a clock edge with req_valid high
//   and req_stall low
// - rsp channel: rsp_valid with rsp_value and rsp_ok; an item leaves on an
//   edge with rsp_valid high and rsp_stall low
// - operands use their low DATA_WIDTH bits as signed numbers (8..64); the
//   value comes back sign-extended to 64 bits
// - the divider, which resolves one quotient bit per stage, sets the depth
//   of the pipeline from acceptance to rsp_valid
// - throughput one item per cycle for every operation mix while the output is not stalled
// - the whole pipeline moves together; when the output item is stalled,
//   every stage holds and req_stall goes high, so nothing is lost or repeated
// - synchronous reset empties all valid bits; data registers are not reset
module checked_int64_alu import cia_pkg::*; #(
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [OP_WIDTH-1:0]    req_operation,
   input  logic [FIELD_WIDTH-1:0] req_left_operand,
   input  logic [FIELD_WIDTH-1:0] req_right_operand,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [FIELD_WIDTH-1:0] rsp_value,
   output logic                   rsp_ok
);

   localparam int unsigned W       = DATA_WIDTH;
   // stages from the input register to aligned unit results
   localparam int unsigned LAT     = W + 2;
   localparam int unsigned MUL_LAT = 4;
   localparam int unsigned MUL_PAD = LAT - MUL_LAT;
   localparam int unsigned ADD_PAD = LAT - 1;

   logic advance;

   // input register and travelling control
   logic         vld_ff [0:LAT];
   op_type       op_ff  [0:LAT];
   logic [W-1:0] a_ff, b_ff;

   // add and subtract share one adder, exact in W+1 bits
   logic [W:0]   sum_in;
   logic [W-1:0] add_value_ff [0:ADD_PAD];
   logic         add_ok_ff    [0:ADD_PAD];

   // multiplier results waiting for the divider
   logic [W-1:0] mul_value, mul_line_value_ff [1:MUL_PAD];
   logic         mul_ok,    mul_line_ok_ff    [1:MUL_PAD];

   logic [W-1:0] div_value;
   logic         div_ok;

   // output register
   logic                   rsp_valid_ff;
   logic [FIELD_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_ok_ff, rsp_ok_in;
   logic [W-1:0]           sel_value;

   // the whole line moves unless a finished item is held at the output
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAT; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i <= LAT; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_valid_ff <= vld_ff[LAT];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff[0] <= op_type'(req_operation);
         a_ff     <= req_left_operand[W-1:0];
         b_ff     <= req_right_operand[W-1:0];
         for (int i = 1; i <= LAT; i++) begin
            op_ff[i] <= op_ff[i-1];
         end
      end
   end

   // subtract adds the inverted right operand plus one
   always_comb begin
      if (op_ff[0] == OP_SUB) begin
         sum_in = {a_ff[W-1], a_ff} + ~{b_ff[W-1], b_ff} + (W+1)'(1);
      end else begin
         sum_in = {a_ff[W-1], a_ff} + {b_ff[W-1], b_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         add_value_ff[0] <= sum_in[W-1:0];
         add_ok_ff[0]    <= (sum_in[W] == sum_in[W-1]);
         for (int i = 1; i <= ADD_PAD; i++) begin
            add_value_ff[i] <= add_value_ff[i-1];
            add_ok_ff[i]    <= add_ok_ff[i-1];
         end
      end
   end

   cia_mul #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_mul (
      .clock   (clock),
      .advance (advance),
      .left    (a_ff),
      .right   (b_ff),
      .product (mul_value),
      .ok      (mul_ok)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         mul_line_value_ff[1] <= mul_value;
         mul_line_ok_ff[1]    <= mul_ok;
         for (int i = 2; i <= MUL_PAD; i++) begin
            mul_line_value_ff[i] <= mul_line_value_ff[i-1];
            mul_line_ok_ff[i]    <= mul_line_ok_ff[i-1];
         end
      end
   end

   cia_div #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_div (
      .clock    (clock),
      .advance  (advance),
      .left     (a_ff),
      .right    (b_ff),
      .quotient (div_value),
      .ok       (div_ok)
   );

   // pick the unit that matches the item's operation
   always_comb begin
      case (op_ff[LAT])
         OP_MUL: begin
            sel_value = mul_line_value_ff[MUL_PAD];
            rsp_ok_in = mul_line_ok_ff[MUL_PAD];
         end
         OP_DIV: begin
            sel_value = div_value;
            rsp_ok_in = div_ok;
         end
         default: begin
            sel_value = add_value_ff[ADD_PAD];
            rsp_ok_in = add_ok_ff[ADD_PAD];
         end
      endcase
      rsp_value_in = FIELD_WIDTH'($signed(sel_value));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_value_ff <= rsp_value_in;
         rsp_ok_ff    <= rsp_ok_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_ok    = rsp_ok_ff;

endmodule

>>> rtl/cia_mul.sv
// pipelined signed multiplier with overflow check, four register stages
module cia_mul import cia_pkg::*; #(
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [DATA_WIDTH-1:0] left,
   input  logic [DATA_WIDTH-1:0] right,
   output logic [DATA_WIDTH-1:0] product,
   output logic                  ok
);

   localparam int unsigned W  = DATA_WIDTH;
   localparam int unsigned H  = (W + 1) / 2;
   localparam int unsigned HU = W - H;
   localparam int unsigned PW = 2 * W;

   // stage 1: magnitudes and product sign
   logic [W-1:0] mag_a_ff, mag_b_ff;
   logic [W-1:0] mag_a_in, mag_b_in;
   logic         neg1_ff;

   // stage 2: partial products
   logic [2*H-1:0]  p00_ff;
   logic [W-1:0]    p01_ff, p10_ff;
   logic [2*HU-1:0] p11_ff;
   logic            neg2_ff;

   // stage 3: full magnitude product
   logic [PW-1:0] prod_ff, prod_in;
   logic          neg3_ff;

   // stage 4: wrapped result and check
   logic [W-1:0] product_ff, product_in;
   logic         ok_ff, ok_in;

   always_comb begin
      mag_a_in = left[W-1]  ? (~left + 1'b1)  : left;
      mag_b_in = right[W-1] ? (~right + 1'b1) : right;
   end

   always_comb begin
      prod_in = PW'(p00_ff)
              + (PW'(p01_ff) << H)
              + (PW'(p10_ff) << H)
              + (PW'(p11_ff) << (2 * H));
   end

   always_comb begin
      product_in = neg3_ff ? (~prod_ff[W-1:0] + 1'b1) : prod_ff[W-1:0];
      // fits below 2^(W-1), or exactly 2^(W-1) when negative
      ok_in = (prod_ff[PW-1:W-1] == '0)
           || (neg3_ff && (prod_ff[PW-1:W-1] == (W+1)'(1))
               && (prod_ff[W-2:0] == '0));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_a_ff   <= mag_a_in;
         mag_b_ff   <= mag_b_in;
         neg1_ff    <= left[W-1] ^ right[W-1];
         p00_ff     <= mag_a_ff[H-1:0] * mag_b_ff[H-1:0];
         p01_ff     <= W'(mag_a_ff[H-1:0] * mag_b_ff[W-1:H]);
         p10_ff     <= W'(mag_a_ff[W-1:H] * mag_b_ff[H-1:0]);
         p11_ff     <= mag_a_ff[W-1:H] * mag_b_ff[W-1:H];
         neg2_ff    <= neg1_ff;
         prod_ff    <= prod_in;
         neg3_ff    <= neg2_ff;
         product_ff <= product_in;
         ok_ff      <= ok_in;
      end
   end

   assign product = product_ff;
   assign ok      = ok_ff;

endmodule

>>> rtl/cia_div.sv
// pipelined signed divider, one quotient bit per stage
module cia_div import cia_pkg::*; #(
   parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  advance,
   input  logic [DATA_WIDTH-1:0] left,
   input  logic [DATA_WIDTH-1:0] right,
   output logic [DATA_WIDTH-1:0] quotient,
   output logic                  ok
);

   localparam int unsigned W = DATA_WIDTH;

   // stage 0 holds magnitudes, stages 1..W each settle one quotient bit
   logic [W-1:0] rem_ff [0:W];
   logic [W-1:0] nq_ff  [0:W];
   logic [W-1:0] den_ff [0:W];
   logic         neg_ff  [0:W];
   logic         fail_ff [0:W];

   logic [W-1:0] quotient_ff, quotient_in;
   logic         ok_ff;
   logic         fail_in;

   assign fail_in = (right == '0)
                 || ((left == {1'b1, {(W-1){1'b0}}}) && (right == '1));

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= '0;
         nq_ff[0]   <= left[W-1]  ? (~left + 1'b1)  : left;
         den_ff[0]  <= right[W-1] ? (~right + 1'b1) : right;
         neg_ff[0]  <= left[W-1] ^ right[W-1];
         fail_ff[0] <= fail_in;
      end
   end

   for (genvar i = 1; i <= W; i++) begin : g_step
      logic [W:0] trial, diff;
      logic [W-1:0] rem_in;
      logic         bit_in;

      always_comb begin
         trial  = {rem_ff[i-1], nq_ff[i-1][W-1]};
         diff   = trial - {1'b0, den_ff[i-1]};
         bit_in = ~diff[W];
         rem_in = bit_in ? diff[W-1:0] : trial[W-1:0];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i]  <= rem_in;
            nq_ff[i]   <= {nq_ff[i-1][W-2:0], bit_in};
            den_ff[i]  <= den_ff[i-1];
            neg_ff[i]  <= neg_ff[i-1];
            fail_ff[i] <= fail_ff[i-1];
         end
      end
   end

   always_comb begin
      if (fail_ff[W]) begin
         quotient_in = '0;
      end else if (neg_ff[W]) begin
         quotient_in = ~nq_ff[W] + 1'b1;
      end else begin
         quotient_in = nq_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quotient_ff <= quotient_in;
         ok_ff       <= ~fail_ff[W];
      end
   end

   assign quotient = quotient_ff;
   assign ok       = ok_ff;

endmodule

>>> test/tb_checked_int64_alu.sv
// self-checking testbench of the checked signed integer alu
`timescale 1ns / 1ps
module tb_checked_int64_alu import cia_pkg::*; ();

   localparam int unsigned LATENCY     = DATA_WIDTH_DEFAULT + 3;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [63:0] I64_MIN     = 64'h8000_0000_0000_0000;
   localparam logic [63:0] I64_MAX     = 64'h7fff_ffff_ffff_ffff;

   typedef struct packed {
      op_type      op;
      logic [63:0] left;
      logic [63:0] right;
   } alu_item_type;

   typedef struct packed {
      logic [63:0] value;
      logic        ok;
   } alu_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [OP_WIDTH-1:0]    req_operation = '0;
   logic [FIELD_WIDTH-1:0] req_left_operand = '0;
   logic [FIELD_WIDTH-1:0] req_right_operand = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [FIELD_WIDTH-1:0] rsp_value;
   logic                   rsp_ok;

   checked_int64_alu u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_left_operand  (req_left_operand),
      .req_right_operand (req_right_operand),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_ok            (rsp_ok)
   );

   always #4 clock = ~clock;

   alu_item_type   pending_items[$];
   alu_result_type expected_results[$];
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;   // chance in a hundred of a gap on the sender
   int unsigned recv_stall_pct = 0;  // chance in a hundred of a stall on the receiver
   int unsigned hold_off_cycles = 0; // long receiver hold-off still to run
   bit          stimulus_done = 1'b0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   // exact arithmetic on 66/130-bit signed values, then a range test
   function automatic alu_result_type predict_alu(alu_item_type it);
      alu_result_type      res;
      logic signed [65:0]  wide_sum;
      logic signed [129:0] wide_prod;
      logic signed [63:0]  a, b;
      a = it.left;
      b = it.right;
      res.ok = 1'b1;
      case (it.op)
         OP_ADD: begin
            wide_sum  = 66'(a) + 66'(b);
            res.value = wide_sum[63:0];
            res.ok    = (wide_sum == 66'(signed'(wide_sum[63:0])));
         end
         OP_SUB: begin
            wide_sum  = 66'(a) - 66'(b);
            res.value = wide_sum[63:0];
            res.ok    = (wide_sum == 66'(signed'(wide_sum[63:0])));
         end
         OP_MUL: begin
            wide_prod = 130'(a) * 130'(b);
            res.value = wide_prod[63:0];
            res.ok    = (wide_prod == 130'(signed'(wide_prod[63:0])));
         end
         default: begin
            // zero divisor and the one quotient that does not fit give 0, not ok
            if (b == 0 || (b == -64'sd1 && a == I64_MIN)) begin
               res.value = '0;
               res.ok    = 1'b0;
            end else begin
               res.value = a / b;  // sv signed divide truncates toward zero
            end
         end
      endcase
      return res;
   endfunction

   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = I64_MIN;
         1: v = I64_MAX;
         2: v = '1;
         3: v = '0;
         4: v = 64'($signed($urandom_range(0, 40)) - 20);
         5: v = 64'(signed'(32'($urandom)));       // products near the 64-bit edge
         6: v = {{33{v[63]}}, v[30:0]};
         7: v = 64'h1 << $urandom_range(0, 63);
         default: ;
      endcase
      return v;
   endfunction

   // driver: offer the head of the queue, drop it once it is taken
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_alu(pending_items.pop_front()));
         end
         if (req_valid && req_stall) begin
            // stalled item holds its payload
         end else if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
         begin
            req_valid         <= 1'b1;
            req_operation     <= pending_items[0].op;
            req_left_operand  <= pending_items[0].left;
            req_right_operand <= pending_items[0].right;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      alu_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected item", rsp_value, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_value !== want.value) report_mismatch("value", rsp_value, want.value);
               if (rsp_ok !== want.ok) report_mismatch("ok", 64'(rsp_ok), 64'(want.ok));
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_stall       <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic add_item(op_type op, logic [63:0] l, logic [63:0] r);
      alu_item_type it;
      it.op    = op;
      it.left  = l;
      it.right = r;
      pending_items.push_back(it);
   endtask

   task automatic add_random(int unsigned n);
      for (int unsigned i = 0; i < n; i++)
         add_item(op_type'($urandom_range(0, 3)), random_operand(), random_operand());
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || expected_results.size() > 0) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: every operation at the extremes, overflow and both failing divides
      add_item(OP_ADD, I64_MAX, 64'd1);
      add_item(OP_ADD, I64_MIN, '1);
      add_item(OP_ADD, I64_MAX, I64_MIN);
      add_item(OP_ADD, '1, '1);
      add_item(OP_SUB, I64_MIN, 64'd1);
      add_item(OP_SUB, '0, I64_MIN);
      add_item(OP_SUB, '1, I64_MIN);
      add_item(OP_SUB, I64_MAX, '1);
      add_item(OP_MUL, I64_MIN, '1);
      add_item(OP_MUL, I64_MIN, 64'd1);
      add_item(OP_MUL, 64'h1_0000_0000, 64'h8000_0000);
      add_item(OP_MUL, 64'hffff_ffff_0000_0000, 64'h8000_0000);
      add_item(OP_MUL, I64_MAX, I64_MAX);
      add_item(OP_MUL, '1, '1);
      add_item(OP_DIV, 64'd7, '0);
      add_item(OP_DIV, I64_MIN, '1);
      add_item(OP_DIV, I64_MIN, 64'd1);
      add_item(OP_DIV, -64'sd7, 64'd2);
      add_item(OP_DIV, 64'd7, -64'sd2);
      add_item(OP_DIV, I64_MAX, I64_MIN);
      add_item(OP_DIV, I64_MIN, I64_MIN);
      add_item(OP_DIV, '0, '1);
      drain();

      // random phases with the idling mixes
      add_random(450);
      drain();
      send_idle_pct = 69;
      add_random(350);
      drain();
      send_idle_pct  = 0;
      recv_stall_pct = 69;
      add_random(350);
      drain();

      // long receiver hold-off while the sender keeps offering, pipeline fills
      recv_stall_pct  = 0;
      hold_off_cycles = 3 * LATENCY;
      add_random(300);
      drain();

      send_idle_pct  = 20;
      recv_stall_pct = 20;
      add_random(400);
      drain();

      repeat (LATENCY + 10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
